FILE: src/window_coefficient_generator_defines.svh
// Assertion helpers shared by the window generator modules.
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef WINDOW_COEFFICIENT_GENERATOR_DEFINES_SVH
`define WINDOW_COEFFICIENT_GENERATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WCG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/wcg_pkg.sv
package wcg_pkg;

  // Shared arithmetic unit widths: dividend / wide operand and divisor / multiplier operand.
  localparam int OPA_W = 48;
  localparam int OPB_W = 34;

  // Internal fixed point: unsigned Q2.30.
  localparam int QI = 30;
  localparam logic [OPA_W-1:0] ONE_QI    = OPA_W'(1) << QI;
  localparam logic [OPA_W-1:0] HALF_QI   = OPA_W'(1) << (QI - 1);
  localparam logic [OPA_W-1:0] PI_QI     = 48'd3373259426;
  localparam logic [OPA_W-1:0] LN2_QI    = 48'd744261118;
  localparam logic [OPA_W-1:0] HAMMING_A = ((48'd25 << QI) + 48'd23) / 48'd46;
  localparam logic [OPA_W-1:0] HAMMING_B = ((48'd21 << QI) + 48'd23) / 48'd46;

  // Series lengths.
  localparam logic [4:0] LN_TERMS  = 5'd14;
  localparam logic [4:0] COS_TERMS = 5'd12;
  localparam logic [4:0] EXP_TERMS = 5'd20;

  // Window method codes.
  localparam logic [2:0] METHOD_RECT    = 3'd0;
  localparam logic [2:0] METHOD_TRI     = 3'd1;
  localparam logic [2:0] METHOD_WELCH   = 3'd2;
  localparam logic [2:0] METHOD_HAMMING = 3'd3;
  localparam logic [2:0] METHOD_HANN    = 3'd4;
  localparam logic [2:0] METHOD_GAUSS   = 3'd5;
  localparam logic [2:0] METHOD_INV     = 3'd6;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_QMUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [OPA_W-1:0] a;
    logic [OPB_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [OPA_W-1:0] res;
  } alu_rsp_t;

  // Position of the highest set bit.
  function automatic logic [2:0] msb_pos(input logic [6:0] v);
    logic [2:0] p;
    p = '0;
    for (int b = 0; b < 7; b++) begin
      if (v[b]) begin
        p = 3'(b);
      end
    end
    return p;
  endfunction

  // Cosine series divisor (2k-1)*(2k).
  function automatic logic [9:0] cos_den(input logic [3:0] k);
    logic [9:0] d;
    case (k)
      4'd1:    d = 10'd2;
      4'd2:    d = 10'd12;
      4'd3:    d = 10'd30;
      4'd4:    d = 10'd56;
      4'd5:    d = 10'd90;
      4'd6:    d = 10'd132;
      4'd7:    d = 10'd182;
      4'd8:    d = 10'd240;
      4'd9:    d = 10'd306;
      4'd10:   d = 10'd380;
      4'd11:   d = 10'd462;
      4'd12:   d = 10'd552;
      default: d = 10'd1;
    endcase
    return d;
  endfunction

endpackage

FILE: src/wcg_alu.sv
`include "window_coefficient_generator_defines.svh"

module wcg_alu import wcg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(OPA_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPA_W - 1);
  localparam int PW = 2 * OPB_W;

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_DIV
  } alu_state_e;

  alu_state_e       state_q;
  alu_op_e          op_q;
  logic [OPB_W-1:0] opa_q;
  logic [OPB_W-1:0] opb_q;
  logic [CNT_W-1:0] cnt_q;
  logic [OPB_W-1:0] rem_q;
  logic [OPA_W-1:0] quo_q;
  logic [OPA_W-1:0] res_q;
  logic             done_q;

  logic [PW-1:0]    prod;
  logic [OPA_W-1:0] mul_res;
  logic [OPB_W:0]   shifted;
  logic [OPB_W:0]   diff;
  logic             ge;
  logic [OPB_W-1:0] rem_d;
  logic [OPA_W-1:0] quo_d;

  // Multiplier, with the Q2.30 rounding for scaled products.
  assign prod = PW'(opa_q) * PW'(opb_q);
  assign mul_res = (op_q == ALU_QMUL) ? OPA_W'((prod + PW'(HALF_QI)) >> QI)
                                      : OPA_W'(prod);

  // One restoring division step per cycle.
  assign shifted = {rem_q, quo_q[OPA_W-1]};
  assign diff    = shifted - {1'b0, opb_q};
  assign ge      = (shifted >= {1'b0, opb_q});
  assign rem_d   = ge ? diff[OPB_W-1:0] : shifted[OPB_W-1:0];
  assign quo_d   = {quo_q[OPA_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      op_q    <= ALU_MUL;
      opa_q   <= '0;
      opb_q   <= '0;
      cnt_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      res_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        A_IDLE: begin
          if (start_i) begin
            op_q  <= req_i.op;
            opa_q <= req_i.a[OPB_W-1:0];
            opb_q <= req_i.b;
            quo_q <= req_i.a;
            rem_q <= '0;
            cnt_q <= '0;
            state_q <= (req_i.op == ALU_DIV) ? A_DIV : A_MUL;
          end
        end
        A_MUL: begin
          res_q   <= mul_res;
          done_q  <= 1'b1;
          state_q <= A_IDLE;
        end
        A_DIV: begin
          quo_q <= quo_d;
          rem_q <= rem_d;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) begin
            res_q   <= quo_d;
            done_q  <= 1'b1;
            state_q <= A_IDLE;
          end
        end
        default: begin
          state_q <= A_IDLE;
        end
      endcase
    end
  end

  assign rsp_o = '{done: done_q, res: res_q};

  // A new operation only starts on an idle unit.
  `WCG_ASSERT_SAME(a_start_idle, start_i, state_q == A_IDLE, "alu started while busy")
  // Completion is a single-cycle pulse.
  `WCG_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "alu done held longer than one cycle")
  // The final division step always reports completion.
  `WCG_ASSERT_NEXT(a_div_end, (state_q == A_DIV) && (cnt_q == CNT_LAST), done_q,
                   "division finished without done")

endmodule

FILE: src/window_coefficient_generator.sv
// Half-window weight generator.
// Input channel (in_valid_i / in_stall_o) carries a half window size H; the
// block answers on the output channel (out_valid_o / out_stall_i) with H items,
// index 0 to H-1, the final one flagged by last_weight_o. H = 0 gives nothing,
// H above MAX_HALF_WINDOW is saturated. The window shape comes from the
// window_method register, written through cfg_valid_i / cfg_ready_o; the
// user must write it only while idle, the block itself does not enforce it.
// One request is handled at a time; in_stall_o stays high until the last
// weight has been loaded into the output register. Every weight is produced
// by a sequencer driving one shared multiply/divide unit, which divides one
// quotient bit per cycle over a 48-bit dividend, so divisions set the rate:
// rectangular needs no arithmetic, triangular, Welch and inverse at most one
// division per weight, Hamming and Hann a 12-term cosine series, Gaussian a
// 20-term series per weight plus a 14-term series once per request for ln(H).
// When the receiver stalls the finished weight waits in the output register
// while the next one is computed. Reset clears the register to rectangular
// and drops any request in progress.
`include "window_coefficient_generator_defines.svh"

module window_coefficient_generator import wcg_pkg::*; #(
  parameter int MAX_HALF_WINDOW = 64,
  parameter int FRAC_BITS       = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [6:0]  half_size_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  weight_index_o,
  output logic [15:0] weight_value_o,
  output logic        last_weight_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_window_method_i
);

  localparam int H_W       = $clog2(MAX_HALF_WINDOW + 1);
  localparam int I_W       = $clog2(MAX_HALF_WINDOW);
  localparam int VAL_W     = FRAC_BITS + 2;
  localparam int OUT_SHIFT = QI - FRAC_BITS;
  localparam logic [6:0]       MAX_H   = 7'(MAX_HALF_WINDOW);
  localparam logic [VAL_W-1:0] ONE_OUT = (VAL_W)'(1) << FRAC_BITS;
  localparam logic [OPA_W-1:0] RND_OUT = OPA_W'(1) << (OUT_SHIFT - 1);

  typedef enum logic [4:0] {
    S_IDLE,
    S_LN_Z,
    S_LN_Z2,
    S_LN_T,
    S_LN_D,
    S_WEIGHT,
    S_FRAC,
    S_RC_PJ,
    S_RC_X,
    S_RC_X2,
    S_COS_T,
    S_COS_D,
    S_RC_B,
    S_G_Y0,
    S_G_Y,
    S_G_N,
    S_EXP_T,
    S_EXP_D,
    S_OUT
  } state_e;

  state_e              state_q;
  logic [2:0]          method_q;
  logic [H_W-1:0]      h_q;
  logic [I_W-1:0]      i_q;
  logic [OPB_W-1:0]    lnh_q;
  logic [OPA_W-1:0]    t_q;
  logic [OPA_W-1:0]    sq_q;
  logic signed [OPA_W:0] sum_q;
  logic [4:0]          k_q;
  logic [5:0]          n_q;
  logic                neg_q;
  logic [VAL_W-1:0]    val_q;
  logic                go_q;
  alu_req_t            req_q;
  logic                out_valid_q;
  logic [5:0]          index_q;
  logic [15:0]         value_q;
  logic                last_q;

  alu_rsp_t            alu_rsp;
  logic [OPA_W-1:0]    r;
  logic signed [OPA_W:0] res_s;
  logic signed [OPA_W:0] sum_add;
  logic signed [OPA_W:0] sum_sub;
  logic signed [OPA_W:0] sum_cos;
  logic [OPA_W-1:0]    cos_c;
  logic [H_W-1:0]      hin_c;
  logic [2:0]          e_in;
  logic [6:0]          m_in;
  logic [7:0]          hm_sum;
  logic [2:0]          e_h;
  logic [OPA_W-1:0]    ln_c;
  logic [H_W-1:0]      hm1;
  logic [2*H_W-1:0]    hh;
  logic [2*H_W-1:0]    d2;
  logic [2*I_W-1:0]    ii;
  logic                neg_c;
  logic [H_W-1:0]      j_c;
  logic [OPA_W-1:0]    a_coef;
  logic [OPA_W-1:0]    b_coef;
  logic [OPA_W-1:0]    rc_v;
  logic [VAL_W-1:0]    rc_out;
  logic [OPA_W-1:0]    exp_v;
  logic [VAL_W-1:0]    exp_out;
  logic [OPA_W-1:0]    s_c;
  logic                out_free;

  wcg_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(go_q),
    .req_i  (req_q),
    .rsp_o  (alu_rsp)
  );

  // Request decode: saturated size and the mantissa split for ln(H).
  assign hin_c  = (half_size_i > MAX_H) ? H_W'(MAX_HALF_WINDOW)
                                        : H_W'(half_size_i);
  assign e_in   = msb_pos(7'(hin_c));
  assign m_in   = 7'd1 << e_in;
  assign hm_sum = 8'(hin_c) + 8'(m_in);

  // Running sums of the series.
  assign r       = alu_rsp.res;
  assign res_s   = signed'({1'b0, r});
  assign sum_add = sum_q + res_s;
  assign sum_sub = sum_q - res_s;
  assign sum_cos = k_q[0] ? sum_sub : sum_add;
  assign cos_c   = (sum_cos < 0) ? '0 :
                   (sum_cos > signed'({1'b0, ONE_QI})) ? ONE_QI : OPA_W'(sum_cos);

  // ln(H) = 2 * atanh series + e * ln2.
  assign e_h  = msb_pos(7'(h_q));
  assign ln_c = (OPA_W'(sum_add) << 1) + OPA_W'(e_h) * LN2_QI;

  // Index-dependent terms.
  assign hm1   = h_q - H_W'(1);
  assign hh    = (2*H_W)'(h_q) * (2*H_W)'(h_q);
  assign d2    = (2*H_W)'(hm1) * (2*H_W)'(hm1);
  assign ii    = (2*I_W)'(i_q) * (2*I_W)'(i_q);
  assign neg_c = (OPA_W'(i_q) << 1) > OPA_W'(hm1);
  assign j_c   = neg_c ? (hm1 - H_W'(i_q)) : H_W'(i_q);

  // Raised cosine combination and scaling to the output format.
  assign a_coef = (method_q == METHOD_HAMMING) ? HAMMING_A : HALF_QI;
  assign b_coef = (method_q == METHOD_HAMMING) ? HAMMING_B : HALF_QI;
  assign rc_v   = neg_q ? ((r >= a_coef) ? '0 : (a_coef - r)) : (a_coef + r);
  assign rc_out = (VAL_W)'((rc_v + RND_OUT) >> OUT_SHIFT);

  // Gaussian: exp(ln2 - r) scaled down by 2^(n+1) with rounding. The
  // remainder of y modulo ln2 is left in t_q by the reduction loop.
  assign s_c     = LN2_QI - t_q;
  assign exp_v   = (OPA_W'(sum_add) + (OPA_W'(1) << n_q)) >> (n_q + 6'd1);
  assign exp_out = (VAL_W)'((exp_v + RND_OUT) >> OUT_SHIFT);

  assign out_free = !out_valid_q || !out_stall_i;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= METHOD_RECT;
    end else if (cfg_valid_i) begin
      method_q <= cfg_window_method_i;
    end
  end

  // Sequencer, arithmetic requests and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      h_q         <= '0;
      i_q         <= '0;
      lnh_q       <= '0;
      t_q         <= '0;
      sq_q        <= '0;
      sum_q       <= '0;
      k_q         <= '0;
      n_q         <= '0;
      neg_q       <= 1'b0;
      val_q       <= '0;
      go_q        <= 1'b0;
      req_q       <= '{op: ALU_MUL, a: '0, b: '0};
      out_valid_q <= 1'b0;
      index_q     <= '0;
      value_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      go_q <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && (half_size_i != 7'd0)) begin
            h_q <= hin_c;
            i_q <= '0;
            if ((method_q == METHOD_GAUSS) && (hin_c != H_W'(1))) begin
              go_q  <= 1'b1;
              req_q <= '{op: ALU_DIV,
                         a: (OPA_W'(7'(hin_c) - m_in) << QI) + OPA_W'(hm_sum >> 1),
                         b: OPB_W'(hm_sum)};
              state_q <= S_LN_Z;
            end else begin
              state_q <= S_WEIGHT;
            end
          end
        end
        S_LN_Z: begin
          if (alu_rsp.done) begin
            t_q   <= r;
            sum_q <= res_s;
            go_q  <= 1'b1;
            req_q <= '{op: ALU_QMUL, a: r, b: OPB_W'(r)};
            state_q <= S_LN_Z2;
          end
        end
        S_LN_Z2: begin
          if (alu_rsp.done) begin
            sq_q  <= r;
            k_q   <= 5'd1;
            go_q  <= 1'b1;
            req_q <= '{op: ALU_QMUL, a: t_q, b: OPB_W'(r)};
            state_q <= S_LN_T;
          end
        end
        S_LN_T: begin
          if (alu_rsp.done) begin
            t_q   <= r;
            go_q  <= 1'b1;
            req_q <= '{op: ALU_DIV, a: r, b: OPB_W'({k_q, 1'b1})};
            state_q <= S_LN_D;
          end
        end
        S_LN_D: begin
          if (alu_rsp.done) begin
            sum_q <= sum_add;
            if (k_q == LN_TERMS) begin
              lnh_q   <= OPB_W'(ln_c);
              state_q <= S_WEIGHT;
            end else begin
              k_q   <= k_q + 5'd1;
              go_q  <= 1'b1;
              req_q <= '{op: ALU_QMUL, a: t_q, b: OPB_W'(sq_q)};
              state_q <= S_LN_T;
            end
          end
        end
        S_WEIGHT: begin
          if (h_q == H_W'(1)) begin
            val_q   <= ONE_OUT;
            state_q <= S_OUT;
          end else begin
            case (method_q)
              METHOD_TRI: begin
                go_q  <= 1'b1;
                req_q <= '{op: ALU_DIV,
                           a: (OPA_W'(h_q - H_W'(i_q)) << FRAC_BITS) + OPA_W'(h_q >> 1),
                           b: OPB_W'(h_q)};
                state_q <= S_FRAC;
              end
              METHOD_WELCH: begin
                go_q  <= 1'b1;
                req_q <= '{op: ALU_DIV,
                           a: (OPA_W'(hh - (2*H_W)'(ii)) << FRAC_BITS) + OPA_W'(hh >> 1),
                           b: OPB_W'(hh)};
                state_q <= S_FRAC;
              end
              METHOD_HAMMING, METHOD_HANN: begin
                neg_q <= neg_c;
                go_q  <= 1'b1;
                req_q <= '{op: ALU_MUL, a: PI_QI, b: OPB_W'(j_c)};
                state_q <= S_RC_PJ;
              end
              METHOD_GAUSS: begin
                go_q  <= 1'b1;
                req_q <= '{op: ALU_MUL, a: OPA_W'(lnh_q), b: OPB_W'(ii)};
                state_q <= S_G_Y0;
              end
              METHOD_INV: begin
                if (i_q == '0) begin
                  val_q   <= ONE_OUT;
                  state_q <= S_OUT;
                end else begin
                  go_q  <= 1'b1;
                  req_q <= '{op: ALU_DIV,
                             a: (OPA_W'(1) << FRAC_BITS) + OPA_W'(i_q >> 1),
                             b: OPB_W'(i_q)};
                  state_q <= S_FRAC;
                end
              end
              METHOD_RECT: begin
                val_q   <= ONE_OUT;
                state_q <= S_OUT;
              end
              default: begin
                val_q   <= ONE_OUT;
                state_q <= S_OUT;
              end
            endcase
          end
        end
        S_FRAC: begin
          if (alu_rsp.done) begin
            val_q   <= (VAL_W)'(r);
            state_q <= S_OUT;
          end
        end
        S_RC_PJ: begin
          if (alu_rsp.done) begin
            go_q  <= 1'b1;
            req_q <= '{op: ALU_DIV, a: r + OPA_W'(hm1 >> 1), b: OPB_W'(hm1)};
            state_q <= S_RC_X;
          end
        end
        S_RC_X: begin
          if (alu_rsp.done) begin
            go_q  <= 1'b1;
            req_q <= '{op: ALU_QMUL, a: r, b: OPB_W'(r)};
            state_q <= S_RC_X2;
          end
        end
        S_RC_X2: begin
          if (alu_rsp.done) begin
            sq_q  <= r;
            t_q   <= ONE_QI;
            sum_q <= signed'({1'b0, ONE_QI});
            k_q   <= 5'd1;
            go_q  <= 1'b1;
            req_q <= '{op: ALU_QMUL, a: ONE_QI, b: OPB_W'(r)};
            state_q <= S_COS_T;
          end
        end
        S_COS_T: begin
          if (alu_rsp.done) begin
            go_q  <= 1'b1;
            req_q <= '{op: ALU_DIV, a: r, b: OPB_W'(cos_den(k_q[3:0]))};
            state_q <= S_COS_D;
          end
        end
        S_COS_D: begin
          if (alu_rsp.done) begin
            t_q   <= r;
            sum_q <= sum_cos;
            go_q  <= 1'b1;
            if (k_q == COS_TERMS) begin
              req_q <= '{op: ALU_QMUL, a: b_coef, b: OPB_W'(cos_c)};
              state_q <= S_RC_B;
            end else begin
              k_q   <= k_q + 5'd1;
              req_q <= '{op: ALU_QMUL, a: r, b: OPB_W'(sq_q)};
              state_q <= S_COS_T;
            end
          end
        end
        S_RC_B: begin
          if (alu_rsp.done) begin
            val_q   <= rc_out;
            state_q <= S_OUT;
          end
        end
        S_G_Y0: begin
          if (alu_rsp.done) begin
            go_q  <= 1'b1;
            req_q <= '{op: ALU_DIV, a: r + OPA_W'(d2 >> 1), b: OPB_W'(d2)};
            state_q <= S_G_Y;
          end
        end
        S_G_Y: begin
          if (alu_rsp.done) begin
            t_q     <= r;
            n_q     <= '0;
            state_q <= S_G_N;
          end
        end
        // Reduce y modulo ln2 by repeated subtraction, counting the subtractions in
        // n; y does not exceed ln(H).
        S_G_N: begin
          if (t_q >= LN2_QI) begin
            t_q <= t_q - LN2_QI;
            n_q <= n_q + 6'd1;
          end else begin
            sq_q  <= s_c;
            t_q   <= ONE_QI;
            sum_q <= signed'({1'b0, ONE_QI});
            k_q   <= 5'd1;
            go_q  <= 1'b1;
            req_q <= '{op: ALU_QMUL, a: ONE_QI, b: OPB_W'(s_c)};
            state_q <= S_EXP_T;
          end
        end
        S_EXP_T: begin
          if (alu_rsp.done) begin
            go_q  <= 1'b1;
            req_q <= '{op: ALU_DIV, a: r, b: OPB_W'(k_q)};
            state_q <= S_EXP_D;
          end
        end
        S_EXP_D: begin
          if (alu_rsp.done) begin
            t_q   <= r;
            sum_q <= sum_add;
            if (k_q == EXP_TERMS) begin
              val_q   <= exp_out;
              state_q <= S_OUT;
            end else begin
              k_q   <= k_q + 5'd1;
              go_q  <= 1'b1;
              req_q <= '{op: ALU_QMUL, a: r, b: OPB_W'(sq_q)};
              state_q <= S_EXP_T;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            index_q     <= 6'(i_q);
            value_q     <= (32'(val_q) > 32'd65535) ? 16'hFFFF : 16'(val_q);
            last_q      <= (H_W'(i_q) == hm1);
            if (H_W'(i_q) == hm1) begin
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_WEIGHT;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign weight_index_o = index_q;
  assign weight_value_o = value_q;
  assign last_weight_o  = last_q;

  // No arithmetic is in flight while waiting for a request.
  `WCG_ASSERT_SAME(a_idle_quiet, state_q == S_IDLE, !go_q && !alu_rsp.done,
                   "arithmetic activity while idle")
  // A free output register is always loaded from the output state.
  `WCG_ASSERT_NEXT(a_out_load, (state_q == S_OUT) && out_free, out_valid_q,
                   "weight not loaded into output register")
  // Indices never pass the largest half window.
  `WCG_ASSERT_SAME(a_index_range, out_valid_q, index_q <= 6'(MAX_HALF_WINDOW - 1),
                   "weight index out of range")

endmodule
